// ----- rtl/core/sace_pkg.sv -----
// Shared types, constants and helper functions of the servo angle command encoder.
package sace_pkg;

  localparam int ANGLE_W = 16;
  localparam int POS_W   = 12;
  localparam int ID_W    = 8;
  localparam int TIME_W  = 14;
  localparam int CFG_W   = 14;
  localparam int REM_W   = 14;
  localparam int IDX_W   = 4;
  localparam int DIG_W   = 4;

  localparam logic [8:0]        ANGLE_MAX = 9'd360;
  localparam logic [POS_W-1:0]  POS_MIN   = 12'd500;
  localparam logic [TIME_W-1:0] TIME_MAX  = 14'd9999;
  localparam logic [TIME_W-1:0] TIME_RST  = 14'd1000;

  // pos = 500 + (angle*2000 + 180)/360 = 500 + ((angle*100 + 9) >> 1) / 9.
  // The division by 9 is a multiply by ceil(2^16/9) and a shift by 16,
  // which is exact for every dividend up to 18004.
  localparam logic [6:0]  MAP_SCALE = 7'd100;
  localparam logic [3:0]  MAP_ROUND = 4'd9;
  localparam logic [12:0] RECIP_9   = 13'd7282;

  // Configuration register indexes.
  localparam logic REG_SERVO_ID  = 1'b0;
  localparam logic REG_MOVE_TIME = 1'b1;

  // Fixed characters of the frame.
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // Frame byte positions where a new number is loaded, and the closing byte.
  localparam logic [IDX_W-1:0] IDX_HASH = 4'd0;
  localparam logic [IDX_W-1:0] IDX_P    = 4'd4;
  localparam logic [IDX_W-1:0] IDX_T    = 4'd9;
  localparam logic [IDX_W-1:0] IDX_LAST = 4'd14;

  // One mapped position on its way from the front end to the queue.
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
  } pos_msg_t;

  // What one frame byte is: a fixed character or a decimal digit of a place.
  typedef struct packed {
    logic       is_digit;
    logic [1:0] place;
    logic [7:0] lit;
  } byte_ctl_t;

  function automatic byte_ctl_t byte_ctl(input logic [IDX_W-1:0] idx);
    byte_ctl_t c;
    c.is_digit = 1'b1;
    c.place    = 2'd0;
    c.lit      = CH_ZERO;
    unique case (idx)
      4'd0:  begin c.is_digit = 1'b0; c.lit = CH_HASH; end
      4'd1:  c.place = 2'd2;
      4'd2:  c.place = 2'd1;
      4'd3:  c.place = 2'd0;
      4'd4:  begin c.is_digit = 1'b0; c.lit = CH_P; end
      4'd5:  c.place = 2'd3;
      4'd6:  c.place = 2'd2;
      4'd7:  c.place = 2'd1;
      4'd8:  c.place = 2'd0;
      4'd9:  begin c.is_digit = 1'b0; c.lit = CH_T; end
      4'd10: c.place = 2'd3;
      4'd11: c.place = 2'd2;
      4'd12: c.place = 2'd1;
      4'd13: c.place = 2'd0;
      default: begin c.is_digit = 1'b0; c.lit = CH_BANG; end
    endcase
    return c;
  endfunction

  // d times ten to the power of place; d is a constant at each call site.
  function automatic logic [REM_W-1:0] pow_mult(input logic [1:0] place, input int d);
    logic [REM_W-1:0] r;
    unique case (place)
      2'd0: r = REM_W'(d);
      2'd1: r = REM_W'(d * 10);
      2'd2: r = REM_W'(d * 100);
      2'd3: r = REM_W'(d * 1000);
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/sace_front.sv -----
// Front end: clamps the angle and maps it to a servo position in two stages.
module sace_front
  import sace_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [ANGLE_W-1:0] angle,
  output pos_msg_t           msg,
  output logic [1:0]         inflight
);

  logic              a_vld_r, a_vld_nxt;
  logic [14:0]       a_y_r, a_y_nxt;
  logic              b_vld_r;
  logic [POS_W-1:0]  b_pos_r, b_pos_nxt;
  logic [8:0]        ang_c;
  logic [15:0]       scaled;
  logic [27:0]       prod;

  always_comb begin
    ang_c     = (angle > 16'(ANGLE_MAX)) ? ANGLE_MAX : angle[8:0];
    scaled    = 16'(ang_c) * 16'(MAP_SCALE) + 16'(MAP_ROUND);
    a_vld_nxt = take;
    a_y_nxt   = scaled[15:1];
    prod      = 28'(a_y_r) * 28'(RECIP_9);
    b_pos_nxt = POS_MIN + prod[27:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= a_vld_r;
    end
    a_y_r   <= a_y_nxt;
    b_pos_r <= b_pos_nxt;
  end

  assign msg.valid = b_vld_r;
  assign msg.pos   = b_pos_r;
  assign inflight  = 2'(a_vld_r) + 2'(b_vld_r);

endmodule

// ----- rtl/core/sace_queue.sv -----
// Small queue of mapped positions between the front end and the serializer.
module sace_queue
  import sace_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pos_msg_t                   push,
  input  logic                       pop,
  output logic                       nonempty,
  output logic [POS_W-1:0]           head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [POS_W-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push.valid ? wrap_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? wrap_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push.valid) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr_r] <= push.pos;
    end
  end

  assign head     = mem[rd_ptr_r];
  assign nonempty = (cnt_r != '0);
  assign count    = cnt_r;

endmodule

// ----- rtl/core/sace_back.sv -----
// Back end: serializes one queued position into the 15-byte command frame.
module sace_back
  import sace_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_nonempty,
  input  logic [POS_W-1:0]  q_head,
  input  logic [ID_W-1:0]   servo_id,
  input  logic [TIME_W-1:0] move_time,
  output logic              pop,
  output logic              out_valid,
  output logic [7:0]        out_char,
  output logic              out_end
);

  logic              active_r, active_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic              vld_r;
  logic [7:0]        char_r, char_nxt;
  logic              end_r, end_nxt;
  logic              fire;
  logic [IDX_W-1:0]  cur;
  byte_ctl_t         ctl;
  logic [DIG_W-1:0]  digit;
  logic [REM_W-1:0]  sub;
  logic [TIME_W-1:0] tsat;

  always_comb begin
    fire = active_r | q_nonempty;
    pop  = !active_r & q_nonempty;
    cur  = active_r ? idx_r : IDX_HASH;
    ctl  = byte_ctl(cur);
    tsat = (move_time > TIME_MAX) ? TIME_MAX : move_time;

    // One decimal digit per byte: compare against the nine multiples of the place.
    digit = '0;
    sub   = '0;
    for (int d = 1; d <= 9; d++) begin
      if (rem_r >= pow_mult(ctl.place, d)) begin
        digit = DIG_W'(d);
        sub   = pow_mult(ctl.place, d);
      end
    end

    char_nxt = ctl.is_digit ? (CH_ZERO + 8'(digit)) : ctl.lit;
    end_nxt  = (cur == IDX_LAST);
    pos_nxt  = pop ? q_head : pos_r;

    rem_nxt = rem_r;
    if (fire) begin
      priority if (cur == IDX_HASH) begin
        rem_nxt = REM_W'(servo_id);
      end else if (cur == IDX_P) begin
        rem_nxt = REM_W'(pos_r);
      end else if (cur == IDX_T) begin
        rem_nxt = REM_W'(tsat);
      end else if (ctl.is_digit) begin
        rem_nxt = rem_r - sub;
      end
    end

    active_nxt = fire && (cur != IDX_LAST);
    idx_nxt    = cur + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
      vld_r    <= 1'b0;
      pos_r    <= '0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      vld_r    <= fire;
      pos_r    <= pos_nxt;
    end
    rem_r  <= rem_nxt;
    char_r <= char_nxt;
    end_r  <= end_nxt;
  end

  assign out_valid = vld_r;
  assign out_char  = char_r;
  assign out_end   = end_r;

endmodule

// ----- rtl/core/servo_angle_command_encoder_top.sv -----
// Servo angle command encoder: angle in, ASCII servo command frame out.
//
// Input: an angle item is taken at a clock edge with start high and busy low.
// Angles above 360 are clamped to 360 and mapped with rounding to a position
// of 500..2500. Each item produces 15 bytes on out_char_out, one per cycle
// with out_valid high: '#', three id digits, 'P', four position digits, 'T',
// four move-time digits and '!', the last flagged by out_frame_end.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 servo id,
// 1 move time in ms, saturated to 9999 when printed); write only when idle.
// Each accepted angle passes the mapping pipeline and the queue, waits there
// while the serializer is busy, and then has its bytes registered by the serializer.
// New items can be taken while earlier frames are still being sent; the byte
// serializer sends one byte per cycle and starts the next frame right after the closing byte. Up to QDEPTH items may
// be held in the mapping pipeline and queue; busy is high while that space is taken.
// Reset clears the pipeline, the queue and the serializer and restores the
// registers to id 0 and 1000 ms. The receiver cannot stall the output.
module servo_angle_command_encoder_top
  import sace_pkg::*;
#(
  parameter int QDEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [ANGLE_W-1:0] in_angle_in,
  output logic               out_valid,
  output logic [7:0]         out_char_out,
  output logic               out_frame_end,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int CW = $clog2(QDEPTH + 1);
  localparam int OW = $clog2(QDEPTH + 3);

  logic [ID_W-1:0]   servo_id_r, servo_id_nxt;
  logic [TIME_W-1:0] move_time_r, move_time_nxt;
  pos_msg_t          msg;
  logic [1:0]        inflight;
  logic              pop, q_nonempty;
  logic [POS_W-1:0]  q_head;
  logic [CW-1:0]     q_count;
  logic [OW-1:0]     occupancy;
  logic              take;

  always_comb begin
    servo_id_nxt  = servo_id_r;
    move_time_nxt = move_time_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SERVO_ID:  servo_id_nxt  = cfg_data[ID_W-1:0];
        REG_MOVE_TIME: move_time_nxt = cfg_data[TIME_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_id_r  <= '0;
      move_time_r <= TIME_RST;
    end else begin
      servo_id_r  <= servo_id_nxt;
      move_time_r <= move_time_nxt;
    end
  end

  // Items in the mapping pipeline count against queue space, so a push never overflows.
  assign occupancy = OW'(q_count) + OW'(inflight);
  assign busy      = (occupancy >= OW'(QDEPTH));
  assign take      = start & !busy;

  sace_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .angle    (in_angle_in),
    .msg      (msg),
    .inflight (inflight)
  );

  sace_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (msg),
    .pop      (pop),
    .nonempty (q_nonempty),
    .head     (q_head),
    .count    (q_count)
  );

  sace_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .servo_id   (servo_id_r),
    .move_time  (move_time_r),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_char   (out_char_out),
    .out_end    (out_frame_end)
  );

endmodule

// ----- rtl/core/sace_checker.sv -----
// Port-level checks of the command frame sequence, bound to the top level.
module sace_checker
  import sace_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic [7:0] out_char_out,
  input logic       out_frame_end
);

  // The frame end flag only ever marks the closing character.
  a_end_is_bang: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_char_out == CH_BANG)
    else $error("frame end not on closing character");

  // Bytes of one frame come in consecutive cycles.
  a_frame_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_end |=> out_valid)
    else $error("gap inside a frame");

  // A byte that follows a closing byte opens a new frame.
  a_frame_opens: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid && out_frame_end) |-> out_char_out == CH_HASH)
    else $error("frame does not open with hash");

  // The id hundreds digit after the opening byte is 0, 1 or 2.
  a_id_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_out == CH_HASH |=>
      out_char_out == CH_ZERO || out_char_out == CH_ZERO + 8'd1 ||
      out_char_out == CH_ZERO + 8'd2)
    else $error("bad id hundreds digit");

endmodule

bind servo_angle_command_encoder_top sace_checker u_sace_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_char_out  (out_char_out),
  .out_frame_end (out_frame_end)
);
